### rtl/r2q_pkg.sv
// ----------------------------------------------------------------------------
// r2q_pkg
// Shared widths, constants and the arctangent table for the RPY to quaternion
// pipeline.
// ----------------------------------------------------------------------------
package r2q_pkg;

    localparam int ANGLE_W       = 16;
    localparam int QUAT_W        = 16;
    localparam int CORDIC_W      = 36;   // Q30 plus headroom for |z| < 4
    localparam int TRIG_W        = 18;   // Q16 cosine / sine
    localparam int ATAN_ENTRIES  = 24;
    localparam int CORDIC_STEPS_DEF = 14;

    localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [CORDIC_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [CORDIC_W-1:0] GAIN_Q30    = 36'sd652032874;
    localparam logic signed [QUAT_W-1:0]   Q14_ONE     = 16'sd16384;

    typedef logic signed [CORDIC_W-1:0] cval_t;
    typedef logic signed [TRIG_W-1:0]   trig_t;

    // one CORDIC lane: x, y, z per angle
    typedef struct packed {
        cval_t x;
        cval_t y;
        cval_t z;
        logic  flip;
    } lane_t;

    typedef struct packed {
        trig_t c;
        trig_t s;
    } cs_t;

    function automatic cval_t atan_q30(input int i);
        logic [31:0] t;
        case (i)
            0:  t = 32'h3243F6A8;
            1:  t = 32'h1DAC6705;
            2:  t = 32'h0FADBAFC;
            3:  t = 32'h07F56EA6;
            4:  t = 32'h03FEAB76;
            5:  t = 32'h01FFD55B;
            6:  t = 32'h00FFFAAA;
            7:  t = 32'h007FFF55;
            8:  t = 32'h003FFFEA;
            9:  t = 32'h001FFFFD;
            10: t = 32'h000FFFFF;
            11: t = 32'h0007FFFF;
            12: t = 32'h0003FFFF;
            13: t = 32'h0001FFFF;
            14: t = 32'h0000FFFF;
            15: t = 32'h00007FFF;
            16: t = 32'h00003FFF;
            17: t = 32'h00001FFF;
            18: t = 32'h00000FFF;
            19: t = 32'h000007FF;
            20: t = 32'h000003FF;
            21: t = 32'h000001FF;
            22: t = 32'h000000FF;
            23: t = 32'h0000007F;
            default: t = 32'h0;
        endcase
        return cval_t'({4'b0, t});
    endfunction

endpackage

### rtl/r2q_cordic.sv
// ----------------------------------------------------------------------------
// r2q_cordic
// Pipelined rotation-mode CORDIC: one register stage per rotation, three
// angles side by side. Gives Q16 cosine and sine of each half angle.
// ----------------------------------------------------------------------------
module r2q_cordic #(
    parameter int STEPS = r2q_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  logic signed [r2q_pkg::ANGLE_W-1:0] ang [3],
    output logic                              out_valid,
    output r2q_pkg::cs_t                      cs [3]
);
    import r2q_pkg::*;

    localparam int N = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;

    lane_t lane_reg [N+1][3];
    logic  vld_reg  [N+1];

    // range reduce each half angle into [-pi/2, pi/2]
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (adv)
            vld_reg[0] <= in_valid;
    end

    for (genvar a = 0; a < 3; a++)
    begin : g_pre
        cval_t z0;
        assign z0 = cval_t'(ang[a]) <<< 16;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                lane_reg[0][a].x <= GAIN_Q30;
                lane_reg[0][a].y <= '0;
                if (z0 > HALF_PI_Q30)
                begin
                    lane_reg[0][a].z    <= z0 - PI_Q30;
                    lane_reg[0][a].flip <= 1'b1;
                end
                else if (z0 < -HALF_PI_Q30)
                begin
                    lane_reg[0][a].z    <= z0 + PI_Q30;
                    lane_reg[0][a].flip <= 1'b1;
                end
                else
                begin
                    lane_reg[0][a].z    <= z0;
                    lane_reg[0][a].flip <= 1'b0;
                end
            end
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < N; i++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (adv)
                vld_reg[i+1] <= vld_reg[i];
        end
        for (genvar a = 0; a < 3; a++)
        begin : g_lane
            lane_t cur;
            assign cur = lane_reg[i][a];
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    lane_reg[i+1][a].flip <= cur.flip;
                    if (!cur.z[CORDIC_W-1])
                    begin
                        lane_reg[i+1][a].x <= cur.x - (cur.y >>> i);
                        lane_reg[i+1][a].y <= cur.y + (cur.x >>> i);
                        lane_reg[i+1][a].z <= cur.z - atan_q30(i);
                    end
                    else
                    begin
                        lane_reg[i+1][a].x <= cur.x + (cur.y >>> i);
                        lane_reg[i+1][a].y <= cur.y - (cur.x >>> i);
                        lane_reg[i+1][a].z <= cur.z + atan_q30(i);
                    end
                end
            end
        end
    end

    // undo the flip and round to Q16
    for (genvar a = 0; a < 3; a++)
    begin : g_out
        cval_t xf, yf, xr, yr;
        assign xf = lane_reg[N][a].flip ? -lane_reg[N][a].x : lane_reg[N][a].x;
        assign yf = lane_reg[N][a].flip ? -lane_reg[N][a].y : lane_reg[N][a].y;
        assign xr = (xf + cval_t'(36'sd8192)) >>> 14;
        assign yr = (yf + cval_t'(36'sd8192)) >>> 14;
        assign cs[a].c = xr[TRIG_W-1:0];
        assign cs[a].s = yr[TRIG_W-1:0];
    end
    assign out_valid = vld_reg[N];

endmodule

### rtl/r2q_product.sv
// ----------------------------------------------------------------------------
// r2q_product
// Product tree: pair products, triple products, sums, then round and
// saturate to Q1.14. Four register stages.
// ----------------------------------------------------------------------------
module r2q_product (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic                               in_valid,
    input  r2q_pkg::cs_t                       cs [3],
    output logic                               out_valid,
    output logic signed [r2q_pkg::QUAT_W-1:0]  quat [4]
);
    import r2q_pkg::*;

    localparam int P2_W = 2 * TRIG_W;
    localparam int P3_W = 3 * TRIG_W;
    localparam int S_W  = P3_W + 1;

    typedef logic signed [P2_W-1:0] p2_t;
    typedef logic signed [P3_W-1:0] p3_t;
    typedef logic signed [S_W-1:0]  s_t;

    // zy pairs: cz cy, sz sy, cz sy, sz cy
    p2_t   zy_reg [4];
    cs_t   xv_reg;
    p3_t   t_reg  [8];
    s_t    sum_reg [4];
    logic signed [QUAT_W-1:0] q_reg [4];
    logic [3:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[2:0], in_valid};
    end

    // form yaw-pitch pair products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zy_reg[0] <= P2_W'(cs[2].c) * P2_W'(cs[1].c);
            zy_reg[1] <= P2_W'(cs[2].s) * P2_W'(cs[1].s);
            zy_reg[2] <= P2_W'(cs[2].c) * P2_W'(cs[1].s);
            zy_reg[3] <= P2_W'(cs[2].s) * P2_W'(cs[1].c);
            xv_reg    <= cs[0];
        end
    end

    // multiply in the roll terms
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg[0] <= P3_W'(zy_reg[0]) * P3_W'(xv_reg.c);
            t_reg[1] <= P3_W'(zy_reg[1]) * P3_W'(xv_reg.s);
            t_reg[2] <= P3_W'(zy_reg[0]) * P3_W'(xv_reg.s);
            t_reg[3] <= P3_W'(zy_reg[1]) * P3_W'(xv_reg.c);
            t_reg[4] <= P3_W'(zy_reg[2]) * P3_W'(xv_reg.c);
            t_reg[5] <= P3_W'(zy_reg[3]) * P3_W'(xv_reg.s);
            t_reg[6] <= P3_W'(zy_reg[3]) * P3_W'(xv_reg.c);
            t_reg[7] <= P3_W'(zy_reg[2]) * P3_W'(xv_reg.s);
        end
    end

    // combine terms
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg[0] <= s_t'(t_reg[0]) + s_t'(t_reg[1]);
            sum_reg[1] <= s_t'(t_reg[2]) - s_t'(t_reg[3]);
            sum_reg[2] <= s_t'(t_reg[4]) + s_t'(t_reg[5]);
            sum_reg[3] <= s_t'(t_reg[6]) - s_t'(t_reg[7]);
        end
    end

    // round to Q14 and saturate
    for (genvar k = 0; k < 4; k++)
    begin : g_sat
        s_t r;
        assign r = (sum_reg[k] + (s_t'(1) <<< 33)) >>> 34;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (r > s_t'(Q14_ONE))
                    q_reg[k] <= Q14_ONE;
                else if (r < -s_t'(Q14_ONE))
                    q_reg[k] <= -Q14_ONE;
                else
                    q_reg[k] <= r[QUAT_W-1:0];
            end
        end
        assign quat[k] = q_reg[k];
    end
    assign out_valid = vld_reg[3];

endmodule

### rtl/rpy_to_quaternion.sv
// Pipeline: CORDIC_STEPS (capped at 24) + 5 register stages from input request to result
// (one range-reduction stage, one per rotation, four in the product tree).
// Throughput: one request per cycle while the output is not stalled; the CORDIC
// stages and product tree are fully pipelined and the whole pipe advances together.
// A stalled output holds the pipe; no request is lost or repeated.
// Reset: rst_n clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// rpy_to_quaternion
// Roll, pitch, yaw (Q2.13) to unit quaternion qz*qy*qx in Q1.14.
// ----------------------------------------------------------------------------
module rpy_to_quaternion #(
    parameter int CORDIC_STEPS = r2q_pkg::CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // roll_angle, pitch_angle, yaw_angle
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // quat_w, quat_x, quat_y, quat_z
);
    import r2q_pkg::*;

    logic adv;
    logic c_valid, p_valid;
    logic signed [ANGLE_W-1:0] ang [3];
    cs_t cs [3];
    logic signed [QUAT_W-1:0] quat [4];

    // advance the pipe unless a result is held at the output
    assign adv = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = adv;

    assign ang[0] = s_axis_tdata[15:0];
    assign ang[1] = s_axis_tdata[31:16];
    assign ang[2] = s_axis_tdata[47:32];

    r2q_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_axis_tvalid),
        .ang       (ang),
        .out_valid (c_valid),
        .cs        (cs)
    );

    r2q_product u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (c_valid),
        .cs        (cs),
        .out_valid (p_valid),
        .quat      (quat)
    );

    assign m_axis_tvalid = p_valid;
    assign m_axis_tdata  = {quat[3], quat[2], quat[1], quat[0]};

    // the quat_w output stays within plus or minus one
    a_w_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd16384 &&
                           $signed(m_axis_tdata[15:0]) >= -16'sd16384))
        else $error("quat_w out of range");

    // a held result does not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("held result changed");

    // input ready follows the output stall
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (m_axis_tready || !m_axis_tvalid))
        else $error("ready mismatch");

endmodule

### tb/sv/rpy_to_quaternion_tb.sv
// ----------------------------------------------------------------------------
// rpy_to_quaternion_tb
// Drives roll/pitch/yaw angle triples into the ZYX quaternion pipeline, first
// with random source gaps and sink stalls, then without. A bit-exact CORDIC
// predictor computes the expected quaternion for each accepted request. Each
// output is compared as a whole against the oldest pending quaternion.
// ----------------------------------------------------------------------------
module rpy_to_quaternion_tb;

    localparam int STEPS     = 14;
    localparam int LATENCY   = STEPS + 6;
    localparam int MAX_CYC   = 400000;
    localparam int N_RANDOM  = 780;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic signed [15:0] w;
    } quat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // roll_angle, pitch_angle, yaw_angle
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // quat_w, quat_x, quat_y, quat_z

    quat_t pending_quats[$];
    int    mismatches = 0;
    int    cycles = 0;
    int    sink_idle = 0;
    bit    src_gaps = 1'b1;
    bit    sink_stalls = 1'b1;

    rpy_to_quaternion #(.CORDIC_STEPS(STEPS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // floor shift, arithmetic on signed 64-bit
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    // cosine and sine of the half angle, both Q16
    function automatic void half_trig(logic signed [15:0] ang,
                                      output longint c, output longint s);
        longint zz, xx, yy, nx;
        longint tbl[24];
        bit     flip;
        tbl = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
        zz = longint'(ang) * 65536;
        xx = 652032874;
        yy = 0;
        flip = 1'b0;
        // fold the half angle into [-pi/2, pi/2]
        if (zz > 64'sd1686629713) begin
            zz = zz - 64'sd3373259426;
            flip = 1'b1;
        end
        else if (zz < -64'sd1686629713) begin
            zz = zz + 64'sd3373259426;
            flip = 1'b1;
        end
        for (int i = 0; i < (STEPS > 24 ? 24 : STEPS); i++) begin
            if (zz >= 0) begin
                nx = xx - floor_shr(yy, i);
                yy = yy + floor_shr(xx, i);
                zz = zz - tbl[i];
            end
            else begin
                nx = xx + floor_shr(yy, i);
                yy = yy - floor_shr(xx, i);
                zz = zz + tbl[i];
            end
            xx = nx;
        end
        if (flip) begin
            xx = -xx;
            yy = -yy;
        end
        c = floor_shr(xx + (64'sd1 << 13), 14);
        s = floor_shr(yy + (64'sd1 << 13), 14);
    endfunction

    // round a Q48 sum to Q14 and clamp to plus or minus one
    function automatic logic signed [15:0] q48_to_q14(longint v);
        longint r;
        r = floor_shr(v + (64'sd1 << 33), 34);
        if (r > 16384)
            r = 16384;
        if (r < -16384)
            r = -16384;
        return r[15:0];
    endfunction

    function automatic quat_t rpy_quat(logic [47:0] angles);
        longint cx, sx, cy, sy, cz, sz;
        quat_t  q;
        half_trig(angles[15:0], cx, sx);
        half_trig(angles[31:16], cy, sy);
        half_trig(angles[47:32], cz, sz);
        q.w = q48_to_q14(cz * cy * cx + sz * sy * sx);
        q.x = q48_to_q14(cz * cy * sx - sz * sy * cx);
        q.y = q48_to_q14(cz * sy * cx + sz * cy * sx);
        q.z = q48_to_q14(sz * cy * cx - cz * sy * sx);
        return q;
    endfunction

    // send one request, with an optional random gap first
    task automatic send_angles(logic [15:0] roll, logic [15:0] pitch, logic [15:0] yaw);
        int gap;
        if (src_gaps && $urandom_range(3) == 0) begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {yaw, pitch, roll};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_quats = {pending_quats, rpy_quat({yaw, pitch, roll})};
    endtask

    task automatic release_source();
        s_axis_tvalid <= 1'b0;
    endtask

    // release the source and wait until the pipe has drained
    task automatic drain_pipe();
        release_source();
        while (pending_quats.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_extremes();
        logic [15:0] vals[7];
        vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001,
                 16'h3244, 16'hCDBC};
        for (int i = 0; i < 7; i++)
            send_angles(vals[i], vals[(i + 2) % 7], vals[(i + 4) % 7]);
        // half angle near the fold points, and saturation candidates
        send_angles(16'h3243, 16'h3245, 16'hCDBB);
        send_angles(16'h6488, 16'h9B78, 16'h6487);
        send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_angles(16'h8000, 16'h8000, 16'h8000);
        send_angles(16'h0000, 16'h0000, 16'h0000);
        drain_pipe();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(4) == 0)
                send_angles(16'($urandom), 16'($urandom), 16'($urandom));
            else
                send_angles(16'($urandom_range(0, 51472) - 25736),
                            16'($urandom_range(0, 51472) - 25736),
                            16'($urandom_range(0, 51472) - 25736));
        end
    endtask

    // random sink stalls in bursts
    always @(posedge clk) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else if (!sink_stalls) begin
            m_axis_tready <= 1'b1;
        end
        else if (sink_idle > 0) begin
            m_axis_tready <= 1'b0;
            sink_idle = sink_idle - 1;
        end
        else if ($urandom_range(5) == 0) begin
            m_axis_tready <= 1'b0;
            sink_idle = $urandom_range(1, 7) - 1;
        end
        else begin
            m_axis_tready <= 1'b1;
        end
    end

    // check each quaternion against the oldest pending one
    always @(posedge clk) begin
        quat_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_quats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected quaternion %h", got);
            end
            else begin
                want = pending_quats.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected w=%0d x=%0d y=%0d z=%0d,",
                                 want.w, want.x, want.y, want.z,
                                 " got w=%0d x=%0d y=%0d z=%0d",
                                 got.w, got.x, got.y, got.z);
                end
            end
        end
    end

    // cycle limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > MAX_CYC) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_random(N_RANDOM / 2);
        drain_pipe();
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        test_random(N_RANDOM / 2);
        release_source();
        while (pending_quats.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/r2q_pkg.sv
rtl/r2q_cordic.sv
rtl/r2q_product.sv
rtl/rpy_to_quaternion.sv
tb/sv/rpy_to_quaternion_tb.sv
